### hdl/selective_repeat_sender_window_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the selective-repeat sender window
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH

// plain property
`define SRSW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// overlapping implication
`define SRSW_ASSERT_IMP(label, ante, cons, msg) \
  `SRSW_ASSERT(label, (ante) |-> (cons), msg)

`endif

### hdl/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Types and constants shared by the selective-repeat sender window.
// ----------------------------------------------------------------------------
`default_nettype none

package srsw_pkg;

  localparam int SeqBits      = 3;
  localparam int PayloadWidth = 32;
  localparam int SeqSpace     = 1 << SeqBits;
  localparam int HalfSpace    = SeqSpace / 2;
  localparam int WinBits      = 3;
  // largest effective window: 3-bit size register, at most half the sequence space
  localparam int MaxWin       = (HalfSpace < 7) ? HalfSpace : 7;

  typedef logic [SeqBits-1:0]      seq_t;
  typedef logic [PayloadWidth-1:0] pay_t;
  typedef logic [WinBits-1:0]      win_t;

  localparam win_t WindowReset = 3'd4;

  localparam logic [1:0] ReqSend    = 2'd0;
  localparam logic [1:0] ReqAck     = 2'd1;
  localparam logic [1:0] ReqTimeout = 2'd2;

  typedef enum logic [1:0] {
    CmdNop,
    CmdSend,
    CmdAck,
    CmdTimeout
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0] req_type;
    pay_t       payload;
    seq_t       seq_num;
    logic       ack_ok;
  } in_t;

  typedef struct packed {
    logic accepted;
    logic tx_valid;
    seq_t tx_seq;
    pay_t tx_payload;
    logic timer_start;
    logic timer_stop;
    seq_t timer_seq;
    seq_t window_base;
    logic window_full;
  } out_t;

  typedef struct packed {
    cmd_kind_e kind;
    seq_t      seq;
    pay_t      payload;
  } cmd_t;

endpackage

`default_nettype wire

### hdl/srsw_front.sv
// ----------------------------------------------------------------------------
// srsw_front
// Classifies an incoming request word into a window command.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_front (
  input  srsw_pkg::in_t  in_word_i,
  output srsw_pkg::cmd_t cmd_o
);
  import srsw_pkg::*;

  always_comb begin
    cmd_o         = '0;
    cmd_o.kind    = CmdNop;
    cmd_o.seq     = in_word_i.seq_num;
    case (in_word_i.req_type)
      ReqSend: begin
        cmd_o.kind    = CmdSend;
        cmd_o.payload = in_word_i.payload;
      end
      // bad checksum: ack is dropped, only status is reported
      ReqAck: begin
        cmd_o.kind = in_word_i.ack_ok ? CmdAck : CmdNop;
      end
      ReqTimeout: begin
        cmd_o.kind = CmdTimeout;
      end
      default: begin
        cmd_o.kind = CmdNop;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/srsw_cmdq.sv
// ----------------------------------------------------------------------------
// srsw_cmdq
// Two-entry command queue between the classifier and the window engine.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_cmdq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  srsw_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output srsw_pkg::cmd_t cmd_o
);
  import srsw_pkg::*;

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  cmd_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

### hdl/srsw_back.sv
// ----------------------------------------------------------------------------
// srsw_back
// Window engine: base/next pointers, ack bitmap, payload store, result word.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  srsw_pkg::win_t cfg_data_i,
  input  logic           cmd_valid_i,
  input  srsw_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           out_pop_i,
  output logic           out_empty_o,
  output srsw_pkg::out_t out_word_o
);
  import srsw_pkg::*;

  localparam int CmpW = (SeqBits > WinBits) ? SeqBits : WinBits;
  localparam int CntW = $clog2(MaxWin + 1);

  typedef enum logic {
    StIdle,
    StExec
  } state_e;

  state_e            state_q;
  cmd_t              cmd_q;
  seq_t              base_q, base_d;
  seq_t              next_q, next_d;
  // marks_q[i] is the ack mark of sequence number base_q + i
  logic [MaxWin-1:0] marks_q, marks_d;
  win_t              win_q;
  out_t              out_q, res;
  logic              out_valid_q;

  pay_t              mem [SeqSpace];
  pay_t              rd_data_q;

  win_t              eff_win;
  seq_t              outstanding, ack_off;
  logic              full_now, ack_in, exec_done, mem_we, run;
  logic [CntW-1:0]   slide_cnt;

  assign cmd_pop_o   = (state_q == StIdle) && cmd_valid_i;
  assign exec_done   = (state_q == StExec) && (!out_valid_q || out_pop_i);
  assign out_empty_o = !out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    if (win_q == '0) begin
      eff_win = win_t'(1);
    end else if (win_q > win_t'(MaxWin)) begin
      eff_win = win_t'(MaxWin);
    end else begin
      eff_win = win_q;
    end
  end

  assign outstanding = next_q - base_q;
  assign ack_off     = cmd_q.seq - base_q;
  assign full_now    = CmpW'(outstanding) >= CmpW'(eff_win);
  assign ack_in      = CmpW'(ack_off) < CmpW'(eff_win);
  assign mem_we      = exec_done && (cmd_q.kind == CmdSend) && !full_now;

  always_comb begin
    base_d    = base_q;
    next_d    = next_q;
    marks_d   = marks_q;
    slide_cnt = '0;
    run       = 1'b1;
    res       = '0;
    case (cmd_q.kind)
      CmdSend: begin
        if (!full_now) begin
          for (int i = 0; i < MaxWin; i++) begin
            if (CmpW'(i) == CmpW'(outstanding)) marks_d[i] = 1'b0;
          end
          res.accepted    = 1'b1;
          res.tx_valid    = 1'b1;
          res.tx_seq      = next_q;
          res.tx_payload  = cmd_q.payload;
          res.timer_start = 1'b1;
          res.timer_seq   = next_q;
          next_d          = next_q + 1'b1;
        end
      end
      CmdAck: begin
        if (ack_in) begin
          for (int i = 0; i < MaxWin; i++) begin
            if (CmpW'(i) == CmpW'(ack_off)) marks_d[i] = 1'b1;
          end
          res.accepted   = 1'b1;
          res.timer_stop = 1'b1;
          res.timer_seq  = cmd_q.seq;
          // base slides over the leading run of acked entries, never past next
          if (cmd_q.seq == base_q) begin
            for (int i = 0; i < MaxWin; i++) begin
              if (run && marks_d[i] && (CmpW'(i) < CmpW'(outstanding))) begin
                slide_cnt = slide_cnt + 1'b1;
              end else begin
                run = 1'b0;
              end
            end
            marks_d = marks_d >> slide_cnt;
            base_d  = base_q + SeqBits'(slide_cnt);
          end
        end
      end
      CmdTimeout: begin
        res.tx_valid    = 1'b1;
        res.tx_seq      = cmd_q.seq;
        res.tx_payload  = rd_data_q;
        res.timer_start = 1'b1;
        res.timer_seq   = cmd_q.seq;
      end
      default: begin
      end
    endcase
    res.window_base = base_d;
    res.window_full = CmpW'(seq_t'(next_d - base_d)) >= CmpW'(eff_win);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cmd_q       <= '0;
      base_q      <= '0;
      next_q      <= '0;
      marks_q     <= '0;
      win_q       <= WindowReset;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        win_q <= cfg_data_i;
      end
      // a result loaded at this edge keeps the word valid
      if (out_pop_i && out_valid_q && !exec_done) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            state_q <= StExec;
          end
        end
        StExec: begin
          if (exec_done) begin
            base_q      <= base_d;
            next_q      <= next_d;
            marks_q     <= marks_d;
            out_q       <= res;
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // payload store, read ahead while the command is dequeued
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[next_q] <= cmd_q.payload;
    end
    if (cmd_pop_o) begin
      rd_data_q <= mem[cmd_i.seq];
    end
  end

endmodule

`default_nettype wire

### hdl/selective_repeat_sender_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Selective-repeat ARQ sender window. Requests (send, ack, timeout) enter
// through a queue-style port (push/full) and are classified into a two-entry
// command queue; full rises when that queue holds two words. The window
// engine dequeues a command and reads the payload store in its idle state,
// then updates base/next and the ack bitmap and loads the result register
// in its exec state. Each request gives exactly one result word, offered
// while empty is low and taken with pop; the engine holds a finished result
// until it is popped, while new requests keep queuing. No clearing pass after
// reset. window_size (reset value 4) comes in on cfg_valid_i/cfg_data_i
// (always ready); the user must write it only while idle: nothing enforces it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "selective_repeat_sender_window_macros.svh"

module selective_repeat_sender_window (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  srsw_pkg::in_t  in_word_i,
  output logic           empty,
  input  logic           pop,
  output srsw_pkg::out_t out_word_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  srsw_pkg::win_t cfg_data_i
);
  import srsw_pkg::*;

  cmd_t dec_cmd, q_cmd;
  logic q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  srsw_front u_front (
    .in_word_i (in_word_i),
    .cmd_o     (dec_cmd)
  );

  srsw_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (dec_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  srsw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .out_pop_i   (pop),
    .out_empty_o (empty),
    .out_word_o  (out_word_o)
  );

  // a sent or resent packet always (re)starts the timer of the same number
  `SRSW_ASSERT_IMP(a_tx_starts_timer, !empty && out_word_o.tx_valid,
                   out_word_o.timer_start && (out_word_o.timer_seq == out_word_o.tx_seq),
                   "tx word without matching timer start")
  // an accepted ack stops its timer and sends nothing
  `SRSW_ASSERT_IMP(a_ack_stops_timer, !empty && out_word_o.accepted && !out_word_o.tx_valid,
                   out_word_o.timer_stop && !out_word_o.timer_start,
                   "accepted ack without timer stop")
  // the engine only dequeues a command the queue holds
  `SRSW_ASSERT(a_pop_when_valid, !q_pop || q_valid, "command popped from empty queue")

endmodule

`default_nettype wire

### sim/srsw_window_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective-repeat sender window monitor
// Watches the request, result and window-size channels of the sender window.
// For every accepted request word it runs its own model of the window
// (base, next, stored payloads, ack marks, window size) and queues the
// expected result. Each popped result is compared field by field with the
// oldest queued word. Reports the error count, the number of results still
// due, and the window state that the stimulus uses to aim its requests.
// ----------------------------------------------------------------------------
module srsw_window_monitor
  import srsw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  logic                full,
  input  in_t                 in_word_i,
  input  logic                empty,
  input  logic                pop,
  input  out_t                out_word_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  win_t                cfg_data_i,
  output int                  error_count_o,
  output int                  pending_o,
  output seq_t                base_o,
  output seq_t                next_o,
  output logic [SeqSpace-1:0] stored_o
);

  win_t                win_size = WindowReset;
  seq_t                base_seq = '0;
  seq_t                next_seq = '0;
  pay_t                payload_mem [SeqSpace];
  logic [SeqSpace-1:0] acked = '0;
  logic [SeqSpace-1:0] stored = '0;
  out_t                expected_words [$];
  out_t                oldest;
  int                  word_index = 0;

  initial begin
    error_count_o = 0;
    pending_o     = 0;
    base_o        = '0;
    next_o        = '0;
    stored_o      = '0;
  end

  // size register clamped to 1 .. half the sequence space
  function automatic int window_limit();
    int w;
    w = int'(win_size);
    if (w < 1) w = 1;
    if (w > HalfSpace) w = HalfSpace;
    return w;
  endfunction

  function automatic logic window_full();
    seq_t outstanding;
    outstanding = next_seq - base_seq;
    return int'(outstanding) >= window_limit();
  endfunction

  function automatic out_t window_step(input in_t req);
    out_t r;
    seq_t seq_off;
    r       = '0;
    seq_off = req.seq_num - base_seq;
    case (req.req_type)
      ReqSend: begin
        if (!window_full()) begin
          payload_mem[next_seq] = req.payload;
          acked[next_seq]       = 1'b0;
          stored[next_seq]      = 1'b1;
          r.accepted    = 1'b1;
          r.tx_valid    = 1'b1;
          r.tx_seq      = next_seq;
          r.tx_payload  = req.payload;
          r.timer_start = 1'b1;
          r.timer_seq   = next_seq;
          next_seq      = next_seq + 1'b1;
        end
      end
      ReqAck: begin
        if (req.ack_ok && int'(seq_off) < window_limit()) begin
          acked[req.seq_num] = 1'b1;
          r.accepted   = 1'b1;
          r.timer_stop = 1'b1;
          r.timer_seq  = req.seq_num;
          // slide over acked entries, never past the next unsent number
          if (req.seq_num == base_seq) begin
            while (base_seq != next_seq && acked[base_seq]) base_seq = base_seq + 1'b1;
          end
        end
      end
      ReqTimeout: begin
        r.tx_valid    = 1'b1;
        r.tx_seq      = req.seq_num;
        r.tx_payload  = payload_mem[req.seq_num];
        r.timer_start = 1'b1;
        r.timer_seq   = req.seq_num;
      end
      default: ;
    endcase
    r.window_base = base_seq;
    r.window_full = window_full();
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count_o = error_count_o + 1;
    $display("%0t MISMATCH result word %0d %s: got %0h want %0h",
             $realtime, word_index, what, got, want);
  endtask

  task automatic check_word(input out_t got, input out_t want);
    if (got.accepted !== want.accepted)
      report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
    if (got.tx_valid !== want.tx_valid)
      report_mismatch("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
    if (got.tx_seq !== want.tx_seq)
      report_mismatch("tx_seq", 32'(got.tx_seq), 32'(want.tx_seq));
    if (got.tx_payload !== want.tx_payload)
      report_mismatch("tx_payload", 32'(got.tx_payload), 32'(want.tx_payload));
    if (got.timer_start !== want.timer_start)
      report_mismatch("timer_start", 32'(got.timer_start), 32'(want.timer_start));
    if (got.timer_stop !== want.timer_stop)
      report_mismatch("timer_stop", 32'(got.timer_stop), 32'(want.timer_stop));
    if (got.timer_seq !== want.timer_seq)
      report_mismatch("timer_seq", 32'(got.timer_seq), 32'(want.timer_seq));
    if (got.window_base !== want.window_base)
      report_mismatch("window_base", 32'(got.window_base), 32'(want.window_base));
    if (got.window_full !== want.window_full)
      report_mismatch("window_full", 32'(got.window_full), 32'(want.window_full));
  endtask

  // values sampled here are the ones before the edge, so handshakes line up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      win_size = WindowReset;
      base_seq = '0;
      next_seq = '0;
      acked    = '0;
      stored   = '0;
      expected_words.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with none due", 32'(out_word_i.tx_payload), '0);
        end else begin
          oldest = expected_words.pop_front();
          check_word(out_word_i, oldest);
        end
        word_index = word_index + 1;
      end
      if (cfg_valid_i && cfg_ready_i) win_size = cfg_data_i;
      if (push && !full) expected_words.push_back(window_step(in_word_i));
    end
    pending_o = expected_words.size();
    base_o    = base_seq;
    next_o    = next_seq;
    stored_o  = stored;
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective-repeat sender window testbench
// Drives request words into the sender window: a directed opening that walks
// the window through fill, refusal, out-of-order and bad acks, timeouts and
// wraparound, then random phases under different window sizes and idle
// patterns on both sides. The monitor predicts and checks every result; this
// module gives the verdict at the end or when the watchdog fires.
// ----------------------------------------------------------------------------
module tb_top;
  import srsw_pkg::*;

  localparam logic [1:0] ReqUnused   = 2'd3;
  localparam int         NumPhases   = 8;
  localparam int         PhaseItems  = 88;
  localparam int         StallLimit  = 4000;
  localparam int         SettleCycles = 6;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  in_t                 in_word = '0;
  logic                empty;
  logic                pop = 1'b0;
  out_t                out_word;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  win_t                cfg_data = '0;

  int                  error_count;
  int                  pending;
  seq_t                win_base;
  seq_t                win_next;
  logic [SeqSpace-1:0] stored_mask;

  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int                  idle_cycles = 0;

  always #4 clk = ~clk;

  selective_repeat_sender_window DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  srsw_window_monitor u_monitor (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push         (push),
    .full         (full),
    .in_word_i    (in_word),
    .empty        (empty),
    .pop          (pop),
    .out_word_i   (out_word),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .error_count_o(error_count),
    .pending_o    (pending),
    .base_o       (win_base),
    .next_o       (win_next),
    .stored_o     (stored_mask)
  );

  // receiver side
  always @(negedge clk) begin
    if (recv_stall_pct == 0) pop <= 1'b1;
    else pop <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog: cycles in which no word moves on any channel
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < StallLimit) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_word(input in_t w);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    push    <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_req(input pay_t pay);
    in_t w;
    w          = '0;
    w.req_type = ReqSend;
    w.payload  = pay;
    w.seq_num  = seq_t'($urandom);
    w.ack_ok   = 1'($urandom);
    push_word(w);
  endtask

  task automatic ack_req(input seq_t seq, input logic ok);
    in_t w;
    w          = '0;
    w.req_type = ReqAck;
    w.payload  = $urandom;
    w.seq_num  = seq;
    w.ack_ok   = ok;
    push_word(w);
  endtask

  task automatic timeout_req(input seq_t seq);
    in_t w;
    w          = '0;
    w.req_type = ReqTimeout;
    w.payload  = $urandom;
    w.seq_num  = seq;
    push_word(w);
  endtask

  // a sequence number whose payload has been stored at least once
  function automatic logic pick_stored(output seq_t seq);
    int start;
    start = $urandom_range(0, SeqSpace - 1);
    for (int i = 0; i < SeqSpace; i++) begin
      seq = seq_t'(start + i);
      if (stored_mask[seq]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // one random request; returns 0 for a word of the unused kind
  task automatic random_request(output logic counted);
    in_t  w;
    seq_t outstanding;
    seq_t seq;
    int   roll;
    roll        = $urandom_range(0, 99);
    outstanding = win_next - win_base;
    w           = '0;
    w.payload   = $urandom;
    w.seq_num   = seq_t'($urandom);
    w.ack_ok    = 1'($urandom);
    if (roll < 40) begin
      w.req_type = ReqSend;
    end else if (roll < 75) begin
      w.req_type = ReqAck;
      if ($urandom_range(0, 99) < 85) begin
        w.seq_num = win_base + seq_t'($urandom_range(0, int'(outstanding)));
        w.ack_ok  = 1'b1;
      end
    end else if (roll < 90) begin
      w.req_type = ReqTimeout;
    end else if (roll < 95) begin
      w.req_type = ReqUnused;
    end else begin
      w.req_type = 2'($urandom);
    end
    if (w.req_type == ReqTimeout) begin
      if (pick_stored(seq)) w.seq_num = seq;
      else w.req_type = ReqSend;
    end
    counted = (w.req_type != ReqUnused);
    push_word(w);
  endtask

  task automatic write_window(input win_t size);
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for all results in, then let the engine go quiet
  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic win_t phase_window(input int p);
    case (p)
      0: return 3'd1;
      1: return 3'd7;
      2: return 3'd0;
      3: return 3'd2;
      4: return 3'd3;
      5: return 3'd5;
      6: return 3'd6;
      default: return 3'd4;
    endcase
  endfunction

  initial begin
    int   done_items;
    logic counted;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed opening, window size at its reset value
    send_req('0);
    send_req('1);
    send_req(32'h5a5a_a5a5);
    send_req($urandom);
    send_req($urandom);          // window full: refused
    ack_req(3'd1, 1'b1);         // out of order, base stays
    ack_req(3'd0, 1'b0);         // bad checksum
    ack_req(3'd5, 1'b1);         // outside the window
    ack_req(3'd0, 1'b1);         // base slides over 0 and 1
    timeout_req(3'd2);
    timeout_req(3'd0);           // entry already acked, still resent
    begin
      in_t w;
      w          = '1;
      w.req_type = ReqUnused;
      push_word(w);
    end
    ack_req(3'd2, 1'b1);
    ack_req(3'd3, 1'b1);         // window empty
    ack_req(3'd5, 1'b1);         // unsent number inside the window
    ack_req(3'd4, 1'b1);         // unsent base: no slide past next
    send_req($urandom);          // sends clear the early marks
    send_req($urandom);
    ack_req(3'd5, 1'b1);
    ack_req(3'd4, 1'b1);
    send_req($urandom);
    send_req('1);                // sequence 7, then wraps
    ack_req(3'd7, 1'b1);
    ack_req(3'd6, 1'b0);
    ack_req(3'd6, 1'b1);         // base wraps to 0
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      write_window(phase_window(p));
      done_items = 0;
      while (done_items < PhaseItems) begin
        random_request(counted);
        if (counted) done_items++;
      end
      drain();
    end

    recv_stall_pct = 0;
    repeat (SettleCycles) @(negedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
